// File: rtl/tlsf_pkg.sv
// Shared constants, types and helper functions of the free-block index.
package tlsf_pkg;

  localparam int OFFSET_SLOTS  = 4096;
  localparam int SLOT_W        = 12;
  localparam int LINK_W        = 13;
  localparam int FIRST_LEVELS  = 32;
  localparam int FL_W          = 5;
  localparam int SECOND_LEVELS = 16;
  localparam int SL_W          = 4;
  localparam int CLASSES       = FIRST_LEVELS * SECOND_LEVELS;
  localparam int CLASS_W       = FL_W + SL_W;
  localparam int BYTES_W       = 32;
  localparam int MIN_W         = 16;

  localparam logic [LINK_W-1:0]  NO_LINK       = LINK_W'(OFFSET_SLOTS);
  localparam logic [BYTES_W-1:0] MIN_FLOOR     = 32'd16;
  localparam logic [MIN_W-1:0]   MIN_RESET     = 16'd16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_NO_FIT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_BOOT_CLR,
    S_IDLE,
    S_MAP,
    S_DECIDE,
    S_SEARCH,
    S_FHEAD,
    S_FCHK,
    S_INS_A,
    S_INS_B,
    S_UNLINK,
    S_CLEAR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    map_en;
    logic    dec_en;
    logic    head_sel;
    logic    ins_a;
    logic    ins_b;
    logic    unlink;
    logic    clr_start;
    logic    clr_step;
    logic    fin;
    status_t code;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    small_size;
    logic    ovf;
    logic    listed;
    logic    ins_hit;
    logic    srch_hit;
    logic    clr_last;
    logic    out_free;
  } sts_t;

  // Index of the highest set bit; zero for a zero word.
  function automatic logic [FL_W-1:0] top_bit(input logic [BYTES_W-1:0] v);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = 0; i < BYTES_W; i++) begin
      if (v[i]) r = FL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [FL_W-1:0] low_bit32(input logic [FIRST_LEVELS-1:0] v);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = FIRST_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) r = FL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [SL_W-1:0] low_bit16(input logic [SECOND_LEVELS-1:0] v);
    logic [SL_W-1:0] r;
    r = '0;
    for (int i = SECOND_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) r = SL_W'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/tlsf_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module tlsf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tlsf_pkg::sts_t sts,
  output tlsf_pkg::cmd_t cmd
);
  import tlsf_pkg::*;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT_CLR;
      code_r  <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_BOOT_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_en = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.dec_en = 1'b1;
        unique case (sts.act)
          ACT_INSERT: begin
            if (sts.listed || sts.small_size) begin
              code_nxt  = ST_IGNORED;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_INS_A;
            end
          end
          ACT_REMOVE: begin
            if (!sts.listed) begin
              code_nxt  = ST_IGNORED;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_UNLINK;
            end
          end
          ACT_FIND: begin
            if (sts.small_size) begin
              code_nxt  = ST_IGNORED;
              state_nxt = S_FINISH;
            end else if (sts.ovf) begin
              code_nxt  = ST_NO_FIT;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
          default: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLEAR;
          end
        endcase
      end
      S_SEARCH: begin
        if (sts.srch_hit) begin
          state_nxt = S_FHEAD;
        end else begin
          code_nxt  = ST_NO_FIT;
          state_nxt = S_FINISH;
        end
      end
      S_FHEAD: begin
        cmd.head_sel = 1'b1;
        state_nxt    = S_FCHK;
      end
      S_FCHK: begin
        if (sts.listed) begin
          state_nxt = S_UNLINK;
        end else begin
          code_nxt  = ST_NO_FIT;
          state_nxt = S_FINISH;
        end
      end
      S_INS_A: begin
        cmd.ins_a = 1'b1;
        code_nxt  = ST_DONE;
        state_nxt = sts.ins_hit ? S_INS_B : S_FINISH;
      end
      S_INS_B: begin
        cmd.ins_b = 1'b1;
        state_nxt = S_FINISH;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        code_nxt   = ST_DONE;
        state_nxt  = S_FINISH;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        code_nxt     = ST_DONE;
        if (sts.clr_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/tlsf_dp.sv
// Datapath: size mapping, bitmaps, list memories and the result register.
module tlsf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlsf_pkg::cmd_t                cmd,
  output tlsf_pkg::sts_t                sts,
  input  logic [47:0]                   in_tdata,
  input  logic                          cfg_wr_en,
  input  logic [tlsf_pkg::MIN_W-1:0]    cfg_wr_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata
);
  import tlsf_pkg::*;

  action_t               act_r;
  logic [SLOT_W-1:0]     b_r;
  logic [BYTES_W-1:0]    bytes_r;
  logic [MIN_W-1:0]      min_r;
  logic [FL_W-1:0]       fl1_r, fl2_r;
  logic [SL_W-1:0]       sl1_r, sl2_r;
  logic [BYTES_W:0]      r_r;
  logic                  small_r;
  logic                  ins_hit_r;
  logic [SLOT_W-1:0]     nb_r;
  logic [FIRST_LEVELS-1:0]  fbm_r;
  logic [SECOND_LEVELS-1:0] sbm_r [FIRST_LEVELS];
  logic [SLOT_W-1:0]     clr_cnt_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [SLOT_W-1:0]     out_found_r;

  logic                  listed_m [OFFSET_SLOTS];
  logic [LINK_W-1:0]     next_m   [OFFSET_SLOTS];
  logic [LINK_W-1:0]     prev_m   [OFFSET_SLOTS];
  logic [CLASS_W-1:0]    cls_m    [OFFSET_SLOTS];
  logic [SLOT_W-1:0]     head_m   [CLASSES];

  logic                  listed_rd;
  logic [LINK_W-1:0]     next_rd, prev_rd;
  logic [CLASS_W-1:0]    cls_rd;
  logic [SLOT_W-1:0]     head_rd;

  // Mapping of the incoming size.
  logic [FL_W-1:0]       fl_b, fl_r2;
  logic [SL_W-1:0]       sl_b, sl_r2;
  logic [BYTES_W:0]      rnd;
  logic                  small_b;

  always_comb begin
    fl_b    = top_bit(bytes_r);
    sl_b    = SL_W'(bytes_r >> (fl_b - FL_W'(SL_W)));
    rnd     = {1'b0, bytes_r} + ((BYTES_W+1)'(1) << (fl_b - FL_W'(SL_W)))
              - (BYTES_W+1)'(1);
    small_b = (bytes_r < MIN_FLOOR) || (bytes_r < {16'd0, min_r});
    fl_r2   = top_bit(r_r[BYTES_W-1:0]);
    sl_r2   = SL_W'(r_r[BYTES_W-1:0] >> (fl_r2 - FL_W'(SL_W)));
  end

  // Bitmap search for a find.
  logic [SECOND_LEVELS-1:0] sl_map;
  logic [FIRST_LEVELS-1:0]  fl_map, mask_lo;
  logic [FL_W-1:0]          srch_fl;
  logic [SL_W-1:0]          srch_sl;
  logic                     srch_hit;

  always_comb begin
    sl_map  = sbm_r[fl2_r] & (16'hFFFF << sl2_r);
    mask_lo = (FIRST_LEVELS'(2) << fl2_r) - FIRST_LEVELS'(1);
    fl_map  = fbm_r & ~mask_lo;
    if (sl_map != '0) begin
      srch_fl  = fl2_r;
      srch_sl  = low_bit16(sl_map);
      srch_hit = 1'b1;
    end else begin
      srch_fl  = low_bit32(fl_map);
      srch_sl  = low_bit16(sbm_r[srch_fl]);
      srch_hit = (fl_map != '0) && (sbm_r[srch_fl] != '0);
    end
  end

  logic [CLASS_W-1:0] head_raddr;
  logic [SLOT_W-1:0]  rd_addr;
  logic               p_none, n_none;
  logic [FL_W-1:0]    ufl;
  logic [SL_W-1:0]    usl;
  logic [SECOND_LEVELS-1:0] sbm_left;

  assign head_raddr = (act_r == ACT_FIND) ? {srch_fl, srch_sl} : {fl1_r, sl1_r};
  assign rd_addr    = cmd.head_sel ? head_rd : b_r;
  assign p_none     = prev_rd[LINK_W-1];
  assign n_none     = next_rd[LINK_W-1];
  assign ufl        = cls_rd[CLASS_W-1:SL_W];
  assign usl        = cls_rd[SL_W-1:0];
  assign sbm_left   = sbm_r[ufl] & ~(SECOND_LEVELS'(1) << usl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RESET;
    end else if (cfg_wr_en) begin
      min_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action_t'(in_tdata[1:0]);
      b_r     <= in_tdata[13:2];
      bytes_r <= in_tdata[45:14];
    end else if (cmd.head_sel) begin
      b_r <= head_rd;
    end
    if (cmd.map_en) begin
      fl1_r   <= fl_b;
      sl1_r   <= sl_b;
      r_r     <= rnd;
      small_r <= small_b;
    end
    if (cmd.dec_en) begin
      fl2_r     <= fl_r2;
      sl2_r     <= sl_r2;
      ins_hit_r <= sbm_r[fl1_r][sl1_r];
    end
    if (cmd.ins_a) nb_r <= head_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbm_r <= '0;
      for (int i = 0; i < FIRST_LEVELS; i++) sbm_r[i] <= '0;
    end else if (cmd.clr_start) begin
      fbm_r <= '0;
      for (int i = 0; i < FIRST_LEVELS; i++) sbm_r[i] <= '0;
    end else if (cmd.ins_a) begin
      fbm_r[fl1_r]        <= 1'b1;
      sbm_r[fl1_r][sl1_r] <= 1'b1;
    end else if (cmd.unlink && p_none && n_none) begin
      // Last block of its class leaves the list.
      sbm_r[ufl][usl] <= 1'b0;
      if (sbm_left == '0) fbm_r[ufl] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
    end
  end

  // Memory reads, one registered port each.
  always_ff @(posedge clk) begin
    listed_rd <= listed_m[rd_addr];
    next_rd   <= next_m[rd_addr];
    prev_rd   <= prev_m[rd_addr];
    cls_rd    <= cls_m[rd_addr];
    head_rd   <= head_m[head_raddr];
  end

  // Memory writes, one port each.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      listed_m[clr_cnt_r] <= 1'b0;
    end else if (cmd.ins_a) begin
      listed_m[b_r] <= 1'b1;
    end else if (cmd.unlink) begin
      listed_m[b_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_a) begin
      next_m[b_r] <= ins_hit_r ? {1'b0, head_rd} : NO_LINK;
    end else if (cmd.unlink && !p_none) begin
      next_m[prev_rd[SLOT_W-1:0]] <= next_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_a) begin
      prev_m[b_r] <= NO_LINK;
    end else if (cmd.ins_b) begin
      prev_m[nb_r] <= {1'b0, b_r};
    end else if (cmd.unlink && !n_none) begin
      prev_m[next_rd[SLOT_W-1:0]] <= prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_a) cls_m[b_r] <= {fl1_r, sl1_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_a) begin
      head_m[{fl1_r, sl1_r}] <= b_r;
    end else if (cmd.unlink && p_none && !n_none) begin
      head_m[cls_rd] <= next_rd[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status_r <= cmd.code;
      out_found_r  <= (cmd.code == ST_DONE && act_r == ACT_FIND) ? b_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_found_r, out_status_r};

  always_comb begin
    sts.act        = act_r;
    sts.small_size = small_r;
    sts.ovf        = r_r[BYTES_W];
    sts.listed     = listed_rd;
    sts.ins_hit    = ins_hit_r;
    sts.srch_hit   = srch_hit;
    sts.clr_last   = &clr_cnt_r;
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

// File: rtl/tlsf_free_block_index.sv
// Top level of the two-level segregated-fit free-block index.
//
// Requests arrive on the in_ stream, one transfer per request, and each gives
// exactly one result transfer on the out_ stream. A request is an insert of a
// block (slot and byte size), a remove of a slot, a find-and-remove for a
// wanted size, or a clear of the whole index.
// The block takes one request at a time and accepts the next one the cycle
// after a result is written; the per-slot link memories, with one registered
// read port and one write port each, set the number of steps. Clear sweeps the
// listed-flag memory one slot a cycle. After reset the same sweep runs with
// in_tready low. The result sits in an output register; the next request is
// accepted while it waits, and a stalled receiver holds back only the
// following result. min_block_bytes is written through cfg_wr_en / cfg_wr_data;
// the user must do so only while idle; the block itself does not enforce it.
module tlsf_free_block_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [1:0] action, [13:2] slot, [45:14] block_bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] status, [13:2] found_offset
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tlsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlsf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // A finished result never overwrites one that is still waiting.
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_tvalid || out_tready))
    else $error("result written over a pending result");

  // One request at a time: no transfer right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in progress");

  // Only a listed block is ever unlinked.
  a_unlink_listed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.unlink |-> sts.listed)
    else $error("unlink of a block that is not listed");

endmodule
